FILE: sv/tdcc_pkg.sv
// Shared types and constants for the triggered dual-channel capture block.
`default_nettype none

package tdcc_pkg;

    localparam int OP_W       = 3;
    localparam int OFFSET_W   = 12;
    localparam int CFG_LEN_W  = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_ARM_TRIG   = 3'd1,
        OP_ARM_SINGLE = 3'd2,
        OP_FREE_RUN   = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic {
        REG_TRIG_RISING = 1'b0,
        REG_CAPTURE_LEN = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: sv/tdcc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tdcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/triggered_dual_channel_capture.sv
// Top level of the triggered dual-channel capture engine with its ring buffer.
//
//  Channel   Direction  Handshake            Beat contents
//  in        in         in_valid / in_stall  op, trigger_level, samples, read offset
//  out       out        out_valid/ out_stall data_a, data_b and capture status
//  config    in         APB write/read       trigger_rising, capture_length
//
// One item is taken every cycle while the output side keeps up.
// A result passes through the ring RAM read stage and then the output register.
// Reset clears all control state; the ring contents are not cleared.
// A stalled output holds its beat, and the input stalls once the read stage is also full.
`default_nettype none

module triggered_dual_channel_capture #(
    parameter int RING_DEPTH  = 4096,
    parameter int MAX_CAPTURE = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tdcc_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [tdcc_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [tdcc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                       pready,

    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [tdcc_pkg::OP_W-1:0]             op,
    input  wire logic                                  trigger_level,
    input  wire logic [SAMPLE_BITS-1:0]                sample_a,
    input  wire logic [SAMPLE_BITS-1:0]                sample_b,
    input  wire logic [tdcc_pkg::OFFSET_W-1:0]         read_offset,
    input  wire logic                                  read_from_trigger,

    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic      [SAMPLE_BITS-1:0]                data_a,
    output logic      [SAMPLE_BITS-1:0]                data_b,
    output logic                                       capturing,
    output logic                                       armed,
    output logic                                       done_res,
    output logic      [$clog2(RING_DEPTH)-1:0]         trigger_index
);

    import tdcc_pkg::*;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int DATA_W = 2 * SAMPLE_BITS;
    localparam logic [CFG_LEN_W-1:0] MAX_SAT =
        (MAX_CAPTURE > (2**CFG_LEN_W - 1)) ? {CFG_LEN_W{1'b1}} : CFG_LEN_W'(MAX_CAPTURE);

    typedef struct packed {
        logic             capturing;
        logic             armed;
        logic             done;
        logic [IDX_W-1:0] trig_pos;
    } status_t;

    // Configuration registers.
    logic                 trig_rising_reg;
    logic [CFG_LEN_W-1:0] cap_len_reg;
    logic                 cfg_wr;

    // Control state.
    logic [IDX_W-1:0]     wi_reg, wi_next;
    logic [IDX_W-1:0]     tp_reg, tp_next;
    logic [CFG_LEN_W-1:0] rem_reg, rem_next;
    logic                 cap_on_reg, cap_on_next;
    logic                 trig_on_reg, trig_on_next;
    logic                 prev_reg, prev_next;

    logic [CFG_LEN_W-1:0] cap_len_sat;
    logic [CFG_LEN_W-1:0] rem_load;
    logic                 edge_hit;

    // Pipeline.
    logic                 in_acc;
    logic                 s1_adv;
    logic                 s1_valid_reg;
    logic                 s1_read_reg;
    status_t              s1_stat_reg;
    status_t              stat_next;
    logic                 out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_a_reg, out_b_reg;
    status_t              out_stat_reg;

    // Ring RAM.
    logic                 ram_we, ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [DATA_W-1:0]    rd_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_TRIG_RISING: prdata = {{(APB_DATA_W-1){1'b0}}, trig_rising_reg};
            REG_CAPTURE_LEN: prdata = APB_DATA_W'(cap_len_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_rising_reg <= 1'b1;
            cap_len_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_TRIG_RISING: trig_rising_reg <= pwdata[0];
                REG_CAPTURE_LEN: cap_len_reg     <= pwdata[CFG_LEN_W-1:0];
                default:         trig_rising_reg <= trig_rising_reg;
            endcase
        end
    end

    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);

    assign cap_len_sat = (cap_len_reg > MAX_SAT) ? MAX_SAT : cap_len_reg;
    assign edge_hit    = trig_rising_reg ? (trigger_level && !prev_reg)
                                         : (!trigger_level && prev_reg);
    assign ram_raddr   = (read_from_trigger ? tp_reg : wi_reg) + IDX_W'(read_offset);

    always_comb
    begin
        wi_next      = wi_reg;
        tp_next      = tp_reg;
        rem_next     = rem_reg;
        cap_on_next  = cap_on_reg;
        trig_on_next = trig_on_reg;
        prev_next    = prev_reg;
        rem_load     = rem_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        if (in_acc)
        begin
            case (op)
                OP_TICK:
                begin
                    if (cap_on_reg)
                    begin
                        prev_next = trigger_level;
                        if (rem_reg == '0 && edge_hit && trig_on_reg)
                        begin
                            tp_next  = wi_reg;
                            rem_load = cap_len_sat;
                        end
                        wi_next  = wi_reg + IDX_W'(1);
                        ram_we   = 1'b1;
                        rem_next = rem_load;
                        if (rem_load != '0)
                        begin
                            rem_next = rem_load - CFG_LEN_W'(1);
                            if (rem_next == '0)
                            begin
                                cap_on_next  = 1'b0;
                                trig_on_next = 1'b0;
                            end
                        end
                    end
                end
                OP_ARM_TRIG:
                begin
                    trig_on_next = 1'b1;
                    prev_next    = trigger_level;
                    cap_on_next  = 1'b1;
                end
                OP_ARM_SINGLE:
                begin
                    rem_next     = CFG_LEN_W'(1);
                    trig_on_next = 1'b0;
                    cap_on_next  = 1'b1;
                end
                OP_FREE_RUN:
                begin
                    cap_on_next = 1'b1;
                end
                OP_READ:
                begin
                    ram_re = 1'b1;
                end
                default:
                begin
                    ram_re = 1'b0;
                end
            endcase
        end
        stat_next.capturing = cap_on_next;
        stat_next.armed     = trig_on_next;
        stat_next.done      = (rem_next == '0) && !trig_on_next;
        stat_next.trig_pos  = tp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg        <= '0;
            tp_reg        <= '0;
            rem_reg       <= '0;
            cap_on_reg    <= 1'b0;
            trig_on_reg   <= 1'b0;
            prev_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wi_reg      <= wi_next;
            tp_reg      <= tp_next;
            rem_reg     <= rem_next;
            cap_on_reg  <= cap_on_next;
            trig_on_reg <= trig_on_next;
            prev_reg    <= prev_next;
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_read_reg <= (op == OP_READ);
            s1_stat_reg <= stat_next;
        end
        if (s1_adv)
        begin
            out_a_reg    <= s1_read_reg ? rd_data[SAMPLE_BITS-1:0] : '0;
            out_b_reg    <= s1_read_reg ? rd_data[DATA_W-1:SAMPLE_BITS] : '0;
            out_stat_reg <= s1_stat_reg;
        end
    end

    tdcc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wi_next),
        .wdata ({sample_b, sample_a}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    assign out_valid     = out_valid_reg;
    assign data_a        = out_a_reg;
    assign data_b        = out_b_reg;
    assign capturing     = out_stat_reg.capturing;
    assign armed         = out_stat_reg.armed;
    assign done_res      = out_stat_reg.done;
    assign trigger_index = out_stat_reg.trig_pos;

    // The trigger can only be armed while capture is enabled.
    assert property (@(posedge clk) disable iff (!rst_n) trig_on_reg |-> cap_on_reg)
        else $error("trigger armed without capture enabled");

    // The countdown never exceeds the saturated length or the single-shot count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg <= MAX_SAT) || (rem_reg == CFG_LEN_W'(1)))
        else $error("remaining count out of range");

    // Read data waiting in the read stage must not be overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> $stable(rd_data))
        else $error("ring read data lost while the read stage is held");

    // The write position moves only on a tick accepted while capturing.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_acc && op == OP_TICK && cap_on_reg) |=> $stable(wi_reg))
        else $error("write position moved without a capturing tick");

    // A finished capture reports no armed trigger.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_stat_reg.done && out_stat_reg.armed))
        else $error("done reported while the trigger is armed");

endmodule

`default_nettype wire
